// ===== rtl/lsuc_pkg.sv =====
// ----------------------------------------------------------------------------
// lsuc_pkg: shared definitions for the line square-up controller
// Command codes, correction constants and the reciprocal used for the cube
// scaling step.
// ----------------------------------------------------------------------------
package lsuc_pkg;

  // Command codes carried on the result channel.
  typedef enum logic [1:0] {
    CMD_NONE       = 2'd0,
    CMD_DRIVE      = 2'd1,
    CMD_DRIVE_STOP = 2'd2,
    CMD_STOP       = 2'd3
  } cmd_t;

  // Configuration register indexes.
  localparam logic CFG_CRUISE_SPEED   = 1'b0;
  localparam logic CFG_LINE_THRESHOLD = 1'b1;

  // Register widths and reset values.
  localparam int SPEED_W   = 10;
  localparam int THRESH_W  = 12;
  localparam int CFG_DATA_W = 12;
  localparam logic signed [SPEED_W-1:0] CRUISE_RESET = 10'sd100;
  localparam logic [THRESH_W-1:0]       THRESH_RESET = 12'd2000;

  // Correction shaping.
  localparam int SLOW_MAG  = 50;
  localparam int CUBE_DIV  = 800000000 / SLOW_MAG;
  localparam int DONE_BAND = 4;
  localparam int MIN_DRIVE = 11;
  localparam int MAG_W     = 6;

  // Cubes at or above this limit saturate the correction magnitude.
  localparam int unsigned CLAMP_LIM = (SLOW_MAG + 1) * CUBE_DIV;

  // Below the clamp limit the cube fits in 30 bits. The divide by CUBE_DIV
  // is a shift by PRE_SHIFT followed by an exact reciprocal multiply for the
  // odd factor: q = (x * RECIP_MUL) >> RECIP_SHIFT for every x below 2^QX_W.
  localparam int PRE_SHIFT   = 10;
  localparam int QX_W        = 20;
  localparam int RECIP_W     = 21;
  localparam int RECIP_SHIFT = 34;
  localparam int unsigned RECIP_MUL = 1099512;

endpackage

// ===== rtl/line_square_up_controller_unit.sv =====
// ----------------------------------------------------------------------------
// line_square_up_controller_unit: line square-up controller
// Drives a two-wheeled robot onto a line and aligns both wheels with it,
// one result per request.
// ----------------------------------------------------------------------------
// A start request or a sample pair that needs no correction goes from
// acceptance straight to the done state and is loaded into the output
// register from there. A sample pair that needs corrections first has both
// corrections worked out one after the other on one shared multiplier, five
// steps each (offset, square, cube, reciprocal scaling, saturation), followed
// by the load into the output register. The input stalls from acceptance
// until the result is loaded into the output register, and stays stalled
// while a finished result waits for an earlier one that is still stalled
// there; a result waiting in the output register does not hold back the
// acceptance of the next request. cfg_ready is always high, and registers
// should be written only while the block is idle.
module line_square_up_controller_unit #(
  parameter int SENSOR_BITS = 12
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Request channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_op,
  input  logic [SENSOR_BITS-1:0]               in_left_level,
  input  logic [SENSOR_BITS-1:0]               in_right_level,
  // Result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output lsuc_pkg::cmd_t                       out_command,
  output logic signed [lsuc_pkg::SPEED_W-1:0]  out_left_drive,
  output logic signed [lsuc_pkg::SPEED_W-1:0]  out_right_drive,
  output logic                                 out_busy_res,
  // Configuration write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic                                 cfg_index,
  input  logic [lsuc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  import lsuc_pkg::*;

  // Magnitude of a level offset, its square and cube, and the multiplier.
  localparam int DW  = (SENSOR_BITS > THRESH_W) ? SENSOR_BITS : THRESH_W;
  localparam int SQW = 2 * DW;
  localparam int CW  = 3 * DW;
  localparam int MAW = (SQW > QX_W) ? SQW : QX_W;
  localparam int MBW = (DW > RECIP_W) ? DW : RECIP_W;
  localparam int PW  = MAW + MBW;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_APPROACH,
    PH_ALIGN
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUB,
    S_SQ,
    S_CUBE,
    S_DIV,
    S_QUO,
    S_DONE
  } state_t;

  state_t                      state_r, state_nxt;
  phase_t                      phase_r;
  logic signed [SPEED_W-1:0]   cruise_r;
  logic [THRESH_W-1:0]         thresh_r;
  logic                        op_r;
  logic                        hit_r;
  logic [SENSOR_BITS-1:0]      lvl_r [2];
  logic                        side_r;
  logic [DW-1:0]               absd_r;
  logic                        dneg_r [2];
  logic [MAG_W-1:0]            mag_r [2];
  logic                        clamp_r;
  logic [PW-1:0]               prod_r;

  logic                        out_valid_r;
  cmd_t                        out_cmd_r;
  logic signed [SPEED_W-1:0]   out_ld_r, out_rd_r;
  logic                        out_busy_r;

  logic                        in_acc;
  logic                        out_free;
  logic                        hit;
  logic                        need_calc;
  logic signed [DW:0]          diff;
  logic [MAW-1:0]              mul_a;
  logic [MBW-1:0]              mul_b;
  logic [PW-1:0]               mul_p;

  logic signed [MAG_W:0]       corr_l, corr_r;
  logic signed [MAG_W:0]       push_l, push_r;
  logic                        band_l, band_r;
  cmd_t                        res_cmd;
  logic signed [SPEED_W-1:0]   res_ld, res_rd;
  phase_t                      res_phase;

  // Signed correction from a saturated magnitude and the offset sign.
  function automatic logic signed [MAG_W:0] corr_f(
    input logic [MAG_W-1:0]        mag,
    input logic                    dneg,
    input logic signed [SPEED_W-1:0] cruise
  );
    logic signed [MAG_W:0] pos;
    pos = $signed({1'b0, mag});
    if (cruise == '0) begin
      return '0;
    end else if (dneg ^ cruise[SPEED_W-1]) begin
      return -pos;
    end
    return pos;
  endfunction

  // Push a correction out to the minimum drive magnitude.
  function automatic logic signed [MAG_W:0] push_f(input logic signed [MAG_W:0] c);
    logic signed [MAG_W:0] lim;
    lim = (MAG_W + 1)'(MIN_DRIVE);
    if (c <= 0) begin
      return (c < -lim) ? c : -lim;
    end
    return (c > lim) ? c : lim;
  endfunction

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // Either sensor at or below the threshold means the line is reached.
  assign hit = (DW'(in_left_level) <= DW'(thresh_r)) ||
               (DW'(in_right_level) <= DW'(thresh_r));
  assign need_calc = in_op &&
                     (((phase_r == PH_APPROACH) && hit) || (phase_r == PH_ALIGN));

  // Offset of the current side's level from the threshold.
  assign diff = $signed({1'b0, DW'(lvl_r[side_r])}) - $signed({1'b0, DW'(thresh_r)});

  // Shared multiplier: square, cube, then reciprocal scaling.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_SQ: begin
        mul_a = MAW'(absd_r);
        mul_b = MBW'(absd_r);
      end
      S_CUBE: begin
        mul_a = MAW'(prod_r[SQW-1:0]);
        mul_b = MBW'(absd_r);
      end
      S_DIV: begin
        mul_a = MAW'(prod_r[PRE_SHIFT +: QX_W]);
        mul_b = MBW'(RECIP_MUL);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = PW'(mul_a) * PW'(mul_b);

  // Result of the current request from the phase and the corrections.
  always_comb begin
    corr_l    = corr_f(mag_r[0], dneg_r[0], cruise_r);
    corr_r    = corr_f(mag_r[1], dneg_r[1], cruise_r);
    push_l    = push_f(corr_l);
    push_r    = push_f(corr_r);
    band_l    = (corr_l <= (MAG_W + 1)'(DONE_BAND)) && (corr_l >= -(MAG_W + 1)'(DONE_BAND));
    band_r    = (corr_r <= (MAG_W + 1)'(DONE_BAND)) && (corr_r >= -(MAG_W + 1)'(DONE_BAND));
    res_cmd   = CMD_NONE;
    res_ld    = '0;
    res_rd    = '0;
    res_phase = PH_IDLE;
    if (!op_r) begin
      res_cmd   = CMD_DRIVE;
      res_ld    = cruise_r;
      res_rd    = cruise_r;
      res_phase = PH_APPROACH;
    end else if (phase_r == PH_APPROACH) begin
      if (!hit_r) begin
        res_phase = PH_APPROACH;
      end else if (band_l && band_r) begin
        res_cmd   = CMD_STOP;
        res_phase = PH_IDLE;
      end else begin
        res_phase = PH_ALIGN;
      end
    end else if (phase_r == PH_ALIGN) begin
      res_ld = SPEED_W'(push_l);
      res_rd = SPEED_W'(push_r);
      if (band_l && band_r) begin
        res_cmd   = CMD_DRIVE_STOP;
        res_phase = PH_IDLE;
      end else begin
        res_cmd   = CMD_DRIVE;
        res_phase = PH_ALIGN;
      end
    end
  end

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = need_calc ? S_SUB : S_DONE;
        end
      end
      S_SUB:  state_nxt = S_SQ;
      S_SQ:   state_nxt = S_CUBE;
      S_CUBE: state_nxt = S_DIV;
      S_DIV:  state_nxt = S_QUO;
      S_QUO:  state_nxt = side_r ? S_DONE : S_SUB;
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Sequencer, datapath registers and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_IDLE;
      cruise_r    <= CRUISE_RESET;
      thresh_r    <= THRESH_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // Configuration writes.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CRUISE_SPEED:   cruise_r <= $signed(cfg_data[SPEED_W-1:0]);
          CFG_LINE_THRESHOLD: thresh_r <= cfg_data[THRESH_W-1:0];
          default: ;
        endcase
      end

      // Request capture.
      if (in_acc) begin
        op_r     <= in_op;
        hit_r    <= hit;
        lvl_r[0] <= in_left_level;
        lvl_r[1] <= in_right_level;
        side_r   <= 1'b0;
        mag_r[0] <= '0;
        mag_r[1] <= '0;
      end

      // Correction steps on the shared multiplier.
      case (state_r)
        S_SUB: begin
          absd_r         <= diff[DW] ? DW'(-diff) : diff[DW-1:0];
          dneg_r[side_r] <= diff[DW];
        end
        S_SQ, S_CUBE: begin
          prod_r <= mul_p;
        end
        S_DIV: begin
          clamp_r <= (prod_r[CW-1:0] >= CW'(CLAMP_LIM));
          prod_r  <= mul_p;
        end
        S_QUO: begin
          mag_r[side_r] <= clamp_r ? MAG_W'(SLOW_MAG) : prod_r[RECIP_SHIFT +: MAG_W];
          side_r        <= 1'b1;
        end
        default: ;
      endcase

      // Output register and phase update; a taken result is replaced or
      // dropped.
      if ((state_r == S_DONE) && out_free) begin
        out_valid_r <= 1'b1;
        out_cmd_r   <= res_cmd;
        out_ld_r    <= res_ld;
        out_rd_r    <= res_rd;
        out_busy_r  <= (res_phase != PH_IDLE);
        phase_r     <= res_phase;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_command     = out_cmd_r;
  assign out_left_drive  = out_ld_r;
  assign out_right_drive = out_rd_r;
  assign out_busy_res    = out_busy_r;

endmodule

// ===== rtl/lsuc_checker.sv =====
// ----------------------------------------------------------------------------
// lsuc_checker: port-level checks for the line square-up controller
// Watches the result channel for a held payload and for commands that
// disagree with the reported busy flag or drive values.
// ----------------------------------------------------------------------------
module lsuc_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_valid,
  input logic                                out_stall,
  input lsuc_pkg::cmd_t                      out_command,
  input logic signed [lsuc_pkg::SPEED_W-1:0] out_left_drive,
  input logic signed [lsuc_pkg::SPEED_W-1:0] out_right_drive,
  input logic                                out_busy_res
);

  import lsuc_pkg::*;

  // A stalled result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_command) &&
      $stable(out_left_drive) && $stable(out_right_drive) && $stable(out_busy_res))
    else $error("stalled result changed");

  // Stop commands always leave the block idle.
  a_stop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_command == CMD_STOP) || (out_command == CMD_DRIVE_STOP))
      |-> !out_busy_res)
    else $error("stop command reported busy");

  // A plain drive keeps the manoeuvre going.
  a_drive_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_command == CMD_DRIVE) |-> out_busy_res)
    else $error("drive command reported idle");

  // Commands without a drive carry zero wheel speeds.
  a_zero_drive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_command == CMD_NONE) || (out_command == CMD_STOP))
      |-> (out_left_drive == '0) && (out_right_drive == '0))
    else $error("non-drive command carries wheel speeds");

endmodule

bind line_square_up_controller_unit lsuc_checker u_lsuc_checker (.*);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the line square-up controller
// Runs a short table of hand-picked requests, then randomised square-up
// sequences under several register settings and idle/stall mixes. Every
// result is checked against the table or a behavioural controller model kept here.
// ----------------------------------------------------------------------------
module tb_top;
  import lsuc_pkg::*;

  localparam int SB             = 12;
  localparam int LEVEL_MAX      = (1 << SB) - 1;
  localparam int CLK_HALF       = 6;
  localparam int RESET_CYCLES   = 7;
  localparam int SETTLE_CYCLES  = 24;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 300;
  localparam int CHUNKS         = 10;
  localparam int CHUNK_ITEMS    = 150;
  localparam int DIR_ROWS       = 28;

  // Request codes and correction shaping.
  localparam logic OP_START    = 1'b0;
  localparam logic OP_SAMPLE   = 1'b1;
  localparam longint CUBE_SCALE = 16000000;
  localparam int CORR_LIMIT    = 50;
  localparam int STOP_BAND     = 4;
  localparam int DRIVE_FLOOR   = 11;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_APPROACH = 2'd1,
    PH_ALIGN    = 2'd2
  } sq_phase_t;

  typedef struct packed {
    cmd_t                      cmd;
    logic signed [SPEED_W-1:0] left_drive;
    logic signed [SPEED_W-1:0] right_drive;
    logic                      busy;
  } wheel_cmd_t;

  typedef struct packed {
    logic       known;
    wheel_cmd_t res;
  } table_cmd_t;

  typedef struct packed {
    logic        is_reg;
    logic        op;
    logic [15:0] a;
    logic [15:0] b;
    logic        known;
    wheel_cmd_t  res;
  } dir_row_t;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic                      in_op;
  logic [SB-1:0]             in_left_level;
  logic [SB-1:0]             in_right_level;
  logic                      out_valid;
  logic                      out_stall;
  cmd_t                      out_command;
  logic signed [SPEED_W-1:0] out_left_drive;
  logic signed [SPEED_W-1:0] out_right_drive;
  logic                      out_busy_res;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic                      cfg_index;
  logic [CFG_DATA_W-1:0]     cfg_data;

  line_square_up_controller_unit #(.SENSOR_BITS(SB)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_left_level  (in_left_level),
    .in_right_level (in_right_level),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_command    (out_command),
    .out_left_drive (out_left_drive),
    .out_right_drive(out_right_drive),
    .out_busy_res   (out_busy_res),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // Model state and register copies, updated on accepted handshakes only.
  sq_phase_t                 model_phase = PH_IDLE;
  logic signed [SPEED_W-1:0] model_cruise = CRUISE_RESET;
  logic [THRESH_W-1:0]       model_thresh = THRESH_RESET;

  wheel_cmd_t pending_commands [$];
  table_cmd_t table_commands [$];

  int fail_count;
  int requests_sent;
  int results_checked;
  int settings_applied;
  int gap_pct;
  int stall_pct;
  int hold_reqs;
  int hold_seen;
  int hold_left;
  int gen_thresh;
  int idle_cycles;
  int chunk_cruise [8];
  int chunk_thresh [8];
  dir_row_t dir_rows [DIR_ROWS];

  // Clock.
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Correction for one level: scaled cube of the offset, signed by the
  // cruise direction and clamped.
  function automatic int level_correction(logic [SB-1:0] level);
    int     lv;
    int     tv;
    longint d;
    longint v;
    lv = int'(level);
    tv = int'(model_thresh);
    d  = lv - tv;
    v  = (d * d * d) / CUBE_SCALE;
    if (model_cruise == 0) return 0;
    if (model_cruise < 0) v = -v;
    if (v > CORR_LIMIT) v = CORR_LIMIT;
    if (v < -CORR_LIMIT) v = -CORR_LIMIT;
    return int'(v);
  endfunction

  // Align drives never fall below the floor; zero goes to the negative side.
  function automatic int pushed_drive(int c);
    if (c <= 0) return (c < -DRIVE_FLOOR) ? c : -DRIVE_FLOOR;
    return (c > DRIVE_FLOOR) ? c : DRIVE_FLOOR;
  endfunction

  function automatic logic in_stop_band(int c);
    return (c <= STOP_BAND) && (c >= -STOP_BAND);
  endfunction

  // Works out the command for one accepted request and advances the phase.
  function automatic wheel_cmd_t predict_wheel_command(logic op, logic [SB-1:0] l,
                                                       logic [SB-1:0] r);
    wheel_cmd_t res;
    int         lc;
    int         rc;
    res = '0;
    res.cmd = CMD_NONE;
    if (op == OP_START) begin
      res.cmd         = CMD_DRIVE;
      res.left_drive  = model_cruise;
      res.right_drive = model_cruise;
      model_phase     = PH_APPROACH;
    end else if (model_phase == PH_APPROACH) begin
      if (l <= model_thresh || r <= model_thresh) begin
        lc = level_correction(l);
        rc = level_correction(r);
        if (in_stop_band(lc) && in_stop_band(rc)) begin
          res.cmd     = CMD_STOP;
          model_phase = PH_IDLE;
        end else begin
          model_phase = PH_ALIGN;
        end
      end
    end else if (model_phase == PH_ALIGN) begin
      lc = level_correction(l);
      rc = level_correction(r);
      res.left_drive  = SPEED_W'(pushed_drive(lc));
      res.right_drive = SPEED_W'(pushed_drive(rc));
      if (in_stop_band(lc) && in_stop_band(rc)) begin
        res.cmd     = CMD_DRIVE_STOP;
        model_phase = PH_IDLE;
      end else begin
        res.cmd = CMD_DRIVE;
      end
    end else begin
      model_phase = PH_IDLE;
    end
    res.busy = (model_phase == PH_APPROACH) || (model_phase == PH_ALIGN);
    return res;
  endfunction

  function automatic dir_row_t req_row(logic op, int l, int r);
    dir_row_t row;
    row = '0;
    row.op = op;
    row.a  = 16'(l);
    row.b  = 16'(r);
    return row;
  endfunction

  function automatic dir_row_t known_row(logic op, int l, int r, cmd_t cmd, int ld, int rd,
                                         logic busy);
    dir_row_t row;
    row                 = req_row(op, l, r);
    row.known           = 1'b1;
    row.res.cmd         = cmd;
    row.res.left_drive  = SPEED_W'(ld);
    row.res.right_drive = SPEED_W'(rd);
    row.res.busy        = busy;
    return row;
  endfunction

  function automatic dir_row_t reg_row(logic idx, int value);
    dir_row_t row;
    row        = '0;
    row.is_reg = 1'b1;
    row.a      = 16'(idx);
    row.b      = 16'(value);
    return row;
  endfunction

  function automatic int level_above(int thr);
    if (thr >= LEVEL_MAX) return LEVEL_MAX;
    return $urandom_range(LEVEL_MAX, thr + 1);
  endfunction

  function automatic int level_near(int thr, int spread);
    int v;
    v = thr - spread + int'($urandom_range(2 * spread, 0));
    if (v < 0) v = 0;
    if (v > LEVEL_MAX) v = LEVEL_MAX;
    return v;
  endfunction

  task automatic report_field(string name, logic signed [15:0] exp_v,
                              logic signed [15:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Monitor: register writes, accepted requests, accepted results, watchdog.
  always @(posedge clk) begin : monitor
    wheel_cmd_t predicted;
    wheel_cmd_t exp_cmd;
    table_cmd_t tag;
    logic       progress;
    if (rst_n) begin
      progress = 1'b0;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_CRUISE_SPEED) model_cruise = $signed(cfg_data[SPEED_W-1:0]);
        else model_thresh = cfg_data[THRESH_W-1:0];
        progress = 1'b1;
      end
      // Results first, so a result never meets an expectation queued this cycle.
      if (out_valid && !out_stall) begin
        progress = 1'b1;
        if (pending_commands.size() == 0) begin
          $error("result with no request outstanding: command %0d", out_command);
          fail_count++;
        end else begin
          exp_cmd = pending_commands.pop_front();
          report_field("command", 16'(exp_cmd.cmd), 16'(out_command));
          report_field("left_drive", 16'(exp_cmd.left_drive), 16'(out_left_drive));
          report_field("right_drive", 16'(exp_cmd.right_drive), 16'(out_right_drive));
          report_field("busy_res", 16'(exp_cmd.busy), 16'(out_busy_res));
          results_checked++;
        end
      end
      if (in_valid && !in_stall) begin
        predicted = predict_wheel_command(in_op, in_left_level, in_right_level);
        tag = table_commands.pop_front();
        pending_commands.push_back(tag.known ? tag.res : predicted);
        progress = 1'b1;
      end
      if (progress) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Result side: random stalls, plus a long hold when one is requested.
  initial begin
    out_stall = 1'b0;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99, 0) < stall_pct);
      end
    end
  end

  // Offers one request after a random gap and waits until it is taken.
  task automatic send_request(logic op, int l, int r, logic known, wheel_cmd_t res);
    table_cmd_t tag;
    while ($urandom_range(99, 0) < gap_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    tag.known = known;
    tag.res   = res;
    table_commands.push_back(tag);
    in_valid       <= 1'b1;
    in_op          <= op;
    in_left_level  <= l[SB-1:0];
    in_right_level <= r[SB-1:0];
    do @(posedge clk); while (in_stall);
    requests_sent++;
  endtask

  // Stops offering and waits for every outstanding result, then settles.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_commands.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_LINE_THRESHOLD) gen_thresh = int'(value);
  endtask

  task automatic set_config(int cruise, int thr);
    drain_results();
    write_reg(CFG_CRUISE_SPEED, cruise[CFG_DATA_W-1:0]);
    write_reg(CFG_LINE_THRESHOLD, thr[CFG_DATA_W-1:0]);
    settings_applied++;
  endtask

  // Mostly complete square-ups (start, approach, line, converging align
  // pairs) with random content; the rest is loose noise requests.
  task automatic run_square_ups(int n_items);
    int first;
    int thr;
    int spread;
    int l;
    int r;
    first = requests_sent;
    thr   = gen_thresh;
    while (requests_sent - first < n_items) begin
      if ($urandom_range(99, 0) < 85) begin
        send_request(OP_START, $urandom_range(LEVEL_MAX, 0), $urandom_range(LEVEL_MAX, 0),
                     1'b0, '0);
        repeat ($urandom_range(4, 0))
          send_request(OP_SAMPLE, level_above(thr), level_above(thr), 1'b0, '0);
        case ($urandom_range(2, 0))
          0: begin
            l = $urandom_range(thr, 0);
            r = level_above(thr);
          end
          1: begin
            l = level_above(thr);
            r = $urandom_range(thr, 0);
          end
          default: begin
            l = level_near(thr, $urandom_range(1200, 0));
            r = level_near(thr, $urandom_range(1200, 0));
          end
        endcase
        send_request(OP_SAMPLE, l, r, 1'b0, '0);
        spread = $urandom_range(1500, 100);
        repeat ($urandom_range(8, 1)) begin
          send_request(OP_SAMPLE, level_near(thr, spread), level_near(thr, spread), 1'b0, '0);
          spread = spread * 2 / 3;
        end
      end else begin
        repeat ($urandom_range(4, 1))
          send_request(($urandom_range(3, 0) == 0) ? OP_START : OP_SAMPLE,
                       $urandom_range(LEVEL_MAX, 0), $urandom_range(LEVEL_MAX, 0), 1'b0, '0);
      end
    end
  endtask

  // Main sequence: reset, directed table, then randomised chunks.
  initial begin : stimulus
    int k;
    int cruise;
    int thr;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_op            = OP_START;
    in_left_level    = '0;
    in_right_level   = '0;
    cfg_valid        = 1'b0;
    cfg_index        = CFG_CRUISE_SPEED;
    cfg_data         = '0;
    fail_count       = 0;
    requests_sent    = 0;
    results_checked  = 0;
    settings_applied = 0;
    gap_pct          = 0;
    stall_pct        = 0;
    hold_reqs        = 0;
    idle_cycles      = 0;
    gen_thresh       = int'(THRESH_RESET);
    chunk_cruise     = '{100, 500, -500, 0, -1, 1, 250, -300};
    chunk_thresh     = '{2000, 0, 4095, 1500, 2500, 1000, 2048, 3000};

    // Hand-picked requests under the reset settings, then a few register
    // changes for zero and extreme cruise speeds.
    dir_rows = '{
      known_row(OP_SAMPLE, 0, 4095, CMD_NONE, 0, 0, 1'b0),       // sample while idle
      known_row(OP_START, 4095, 0, CMD_DRIVE, 100, 100, 1'b1),
      known_row(OP_SAMPLE, 4095, 4095, CMD_NONE, 0, 0, 1'b1),    // both above the line
      known_row(OP_SAMPLE, 2000, 2000, CMD_STOP, 0, 0, 1'b0),    // exactly on threshold
      known_row(OP_START, 0, 0, CMD_DRIVE, 100, 100, 1'b1),
      known_row(OP_SAMPLE, 0, 4095, CMD_NONE, 0, 0, 1'b1),       // approach to align
      known_row(OP_SAMPLE, 0, 4095, CMD_DRIVE, -50, 50, 1'b1),   // both clamped
      req_row(OP_SAMPLE, 2430, 1570),                            // edge of the stop band
      known_row(OP_START, 0, 4095, CMD_DRIVE, 100, 100, 1'b1),
      req_row(OP_SAMPLE, 2431, 1999),                            // just outside the band
      req_row(OP_SAMPLE, 2934, 1066),                            // just under the clamp
      req_row(OP_SAMPLE, 2935, 1065),                            // just over the clamp
      known_row(OP_START, 1, 2, CMD_DRIVE, 100, 100, 1'b1),      // restart while aligning
      req_row(OP_SAMPLE, 2000, 2001),
      known_row(OP_SAMPLE, 4095, 0, CMD_NONE, 0, 0, 1'b0),
      known_row(OP_START, 4095, 4095, CMD_DRIVE, 100, 100, 1'b1),
      req_row(OP_SAMPLE, 0, 0),
      req_row(OP_SAMPLE, 2000, 1000),                            // zero pushed negative
      req_row(OP_SAMPLE, 2100, 1950),
      reg_row(CFG_CRUISE_SPEED, 0),
      known_row(OP_START, 0, 0, CMD_DRIVE, 0, 0, 1'b1),
      known_row(OP_SAMPLE, 0, 0, CMD_STOP, 0, 0, 1'b0),          // zero cruise stops
      reg_row(CFG_CRUISE_SPEED, -500),
      known_row(OP_START, 0, 0, CMD_DRIVE, -500, -500, 1'b1),
      req_row(OP_SAMPLE, 0, 4095),
      known_row(OP_SAMPLE, 0, 4095, CMD_DRIVE, 50, -50, 1'b1),   // direction reversed
      reg_row(CFG_LINE_THRESHOLD, 4095),
      // Both levels on the new threshold end the align with the pushed drives.
      known_row(OP_SAMPLE, 4095, 4095, CMD_DRIVE_STOP, -11, -11, 1'b0)
    };

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < DIR_ROWS; k++) begin
      if (dir_rows[k].is_reg) begin
        drain_results();
        write_reg(dir_rows[k].a[0], dir_rows[k].b[CFG_DATA_W-1:0]);
      end else begin
        send_request(dir_rows[k].op, int'(dir_rows[k].a), int'(dir_rows[k].b),
                     dir_rows[k].known, dir_rows[k].res);
      end
    end

    // Random chunks, each with its own settings and idle/stall mix.
    for (k = 0; k < CHUNKS; k++) begin
      if (k < 8) begin
        cruise = chunk_cruise[k];
        thr    = chunk_thresh[k];
      end else begin
        cruise = int'($urandom_range(1000, 0)) - 500;
        thr    = $urandom_range(LEVEL_MAX, 0);
      end
      set_config(cruise, thr);
      case (k % 4)
        0: begin
          gap_pct   = 0;
          stall_pct = 0;
        end
        1: begin
          gap_pct   = 53;
          stall_pct = 0;
        end
        2: begin
          gap_pct   = 0;
          stall_pct = 53;
        end
        default: begin
          gap_pct   = 10;
          stall_pct = 10;
        end
      endcase
      // Hold the result side off while requests keep coming, to fill the block.
      if (k == 6) hold_reqs++;
      run_square_ups(CHUNK_ITEMS);
    end
    drain_results();

    if (pending_commands.size() != 0) begin
      $error("%0d results never arrived", pending_commands.size());
      fail_count++;
    end
    $display("Run covered %0d requests and %0d checked results over %0d register settings,",
             requests_sent, results_checked, settings_applied);
    $display("with idle and stall mixes on both sides and one long hold on the result side.");
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
